/* rtl/core/arlg_pkg.sv */
// shared types, constants and reset values for the adaptive rate ladder governor
`timescale 1ns / 1ps

package arlg_pkg;

    localparam int SCORE_MAX   = 120;
    localparam int BLOCK_MAX   = 480;
    localparam int WORK_BITS   = 24;

    localparam int TRIP_W      = 7;
    localparam int SCORE_W     = ($clog2(SCORE_MAX + 5) > TRIP_W) ? $clog2(SCORE_MAX + 5) : TRIP_W;
    localparam int BLOCK_W     = $clog2(BLOCK_MAX + 1);
    localparam int HOLD_W      = 7;
    localparam int RATE_W      = 8;
    localparam int PERIOD_W    = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = ((WORK_BITS > PERIOD_W) ? WORK_BITS : PERIOD_W) + 7;

    localparam int BLOCK_BASE  = 45;
    localparam int HOLD_FRAMES = 120;
    localparam int BEHIND_STEP = 4;
    localparam int PCT_SCALE   = 100;
    localparam int BEHIND_PCT  = 115;
    localparam int AHEAD_PCT   = 95;

    localparam logic [RATE_W-1:0]   RST_TOP_RATE     = RATE_W'(60);
    localparam logic [RATE_W-1:0]   RST_FLOOR_RATE   = RATE_W'(30);
    localparam logic [PERIOD_W-1:0] RST_TOP_PERIOD   = PERIOD_W'(16666);
    localparam logic [PERIOD_W-1:0] RST_FLOOR_PERIOD = PERIOD_W'(33333);
    localparam logic [TRIP_W-1:0]   RST_BEHIND_TRIP  = TRIP_W'(60);
    localparam logic [TRIP_W-1:0]   RST_AHEAD_TRIP   = TRIP_W'(60);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADAPTIVE_ENABLE = 3'd0,
        REG_TOP_RATE        = 3'd1,
        REG_FLOOR_RATE      = 3'd2,
        REG_TOP_PERIOD      = 3'd3,
        REG_FLOOR_PERIOD    = 3'd4,
        REG_BEHIND_TRIP     = 3'd5,
        REG_AHEAD_TRIP      = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        CHG_NONE = 2'd0,
        CHG_DOWN = 2'd1,
        CHG_UP   = 2'd2
    } change_t;

    typedef struct packed {
        logic                adaptive_enable;
        logic [RATE_W-1:0]   top_rate;
        logic [RATE_W-1:0]   floor_rate;
        logic [PERIOD_W-1:0] top_period_us;
        logic [PERIOD_W-1:0] floor_period_us;
        logic [TRIP_W-1:0]   behind_trip;
        logic [TRIP_W-1:0]   ahead_trip;
    } arlg_cfg_t;

    typedef struct packed {
        logic                 action;
        logic [RATE_W-1:0]    requested_rate;
        logic [RATE_W-1:0]    guest_rate;
        logic [WORK_BITS-1:0] work_us;
    } arlg_item_t;

    typedef struct packed {
        logic               ladder_loaded;
        logic               rung;
        logic [SCORE_W-1:0] behind_score;
        logic [SCORE_W-1:0] ahead_score;
        logic [BLOCK_W-1:0] up_block_count;
        logic [BLOCK_W-1:0] up_block_length;
        logic [HOLD_W-1:0]  frames_since_climb;
    } arlg_state_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              rung_index;
        logic              ladder_active;
        change_t           change;
    } arlg_result_t;

endpackage

/* rtl/core/adaptive_rate_ladder_governor.sv */
// top level of the adaptive rate ladder governor: config registers, word pipeline, state
`timescale 1ns / 1ps

// Usage
// - input channel (in_valid/in_ready) carries one word: action, requested_rate,
//   guest_rate, work_us; output channel (out_valid/out_ready) returns one word:
//   rate, rung_index, ladder_active, change
// - config port: cfg_write with cfg_index and cfg_data, taken on the clock edge;
//   the user must write only while no word is in flight, the block does not enforce it
// - an accepted word sits in the input register; its result is loaded into the
//   output register, raising out_valid, once that register is empty or being read
// - throughput is one word per cycle while the receiver keeps out_ready high; the
//   ladder state register is updated in the same cycle the word moves from input
//   to output register, so words back to back see each other's updates in order
// - when the receiver stalls, the output register holds its word and the input
//   register holds one more; in_ready drops only when both are full
// - reset (rst_n low, asynchronous) empties both registers, loads config defaults
//   (disabled, rates 60/30, periods 16666/33333 us, trips 60/60) and clears the
//   ladder to the top rung with a block length of 45

module adaptive_rate_ladder_governor
    import arlg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [RATE_W-1:0]     requested_rate,
    input  logic [RATE_W-1:0]     guest_rate,
    input  logic [WORK_BITS-1:0]  work_us,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [RATE_W-1:0]     rate,
    output logic                  rung_index,
    output logic                  ladder_active,
    output logic [1:0]            change
);

    arlg_cfg_t    cfg_reg;
    arlg_state_t  st_reg;
    arlg_state_t  st_next;
    arlg_item_t   item_reg;
    arlg_result_t res_reg;
    arlg_result_t res_next;
    logic         s1_valid_reg;
    logic         out_valid_reg;
    logic         s1_advance;
    logic         in_fire;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adaptive_enable <= 1'b0;
            cfg_reg.top_rate        <= RST_TOP_RATE;
            cfg_reg.floor_rate      <= RST_FLOOR_RATE;
            cfg_reg.top_period_us   <= RST_TOP_PERIOD;
            cfg_reg.floor_period_us <= RST_FLOOR_PERIOD;
            cfg_reg.behind_trip     <= RST_BEHIND_TRIP;
            cfg_reg.ahead_trip      <= RST_AHEAD_TRIP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ADAPTIVE_ENABLE: cfg_reg.adaptive_enable <= cfg_data[0];
                REG_TOP_RATE:        cfg_reg.top_rate        <= cfg_data[RATE_W-1:0];
                REG_FLOOR_RATE:      cfg_reg.floor_rate      <= cfg_data[RATE_W-1:0];
                REG_TOP_PERIOD:      cfg_reg.top_period_us   <= cfg_data[PERIOD_W-1:0];
                REG_FLOOR_PERIOD:    cfg_reg.floor_period_us <= cfg_data[PERIOD_W-1:0];
                REG_BEHIND_TRIP:     cfg_reg.behind_trip     <= cfg_data[TRIP_W-1:0];
                REG_AHEAD_TRIP:      cfg_reg.ahead_trip      <= cfg_data[TRIP_W-1:0];
                default:             ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.action         <= action;
            item_reg.requested_rate <= requested_rate;
            item_reg.guest_rate     <= guest_rate;
            item_reg.work_us        <= work_us;
        end
    end

    arlg_update u_update (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // ladder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.ladder_loaded      <= 1'b0;
            st_reg.rung               <= 1'b0;
            st_reg.behind_score       <= '0;
            st_reg.ahead_score        <= '0;
            st_reg.up_block_count     <= '0;
            st_reg.up_block_length    <= BLOCK_W'(BLOCK_BASE);
            st_reg.frames_since_climb <= HOLD_W'(HOLD_FRAMES);
        end
        else if (s1_advance)
        begin
            st_reg <= st_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign rate          = res_reg.rate;
    assign rung_index    = res_reg.rung_index;
    assign ladder_active = res_reg.ladder_active;
    assign change        = res_reg.change;

    // checks
    a_pass_through_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ladder_active |-> change == CHG_NONE && !rung_index)
        else $error("pass-through word carries ladder fields");

    a_step_down_rung: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && change == CHG_DOWN |-> rung_index)
        else $error("step down word not on floor rung");

    a_step_up_rung: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && change == CHG_UP |-> !rung_index)
        else $error("step up word not on top rung");

    a_scores_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.behind_score <= SCORE_W'(SCORE_MAX) && st_reg.ahead_score <= SCORE_W'(SCORE_MAX))
        else $error("score above saturation level");

    a_block_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.up_block_length >= BLOCK_W'(BLOCK_BASE)
        && st_reg.up_block_length <= BLOCK_W'(BLOCK_MAX))
        else $error("climb block length out of range");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(st_reg))
        else $error("ladder state moved without a word");

endmodule

/* rtl/core/arlg_update.sv */
// per-word ladder decision: next governor state and result from current state and word
`timescale 1ns / 1ps

module arlg_update
    import arlg_pkg::*;
(
    input  arlg_cfg_t    cfg,
    input  arlg_state_t  st,
    input  arlg_item_t   item,
    output arlg_state_t  st_next,
    output arlg_result_t res
);

    logic [PROD_W-1:0]  work_x100;
    logic [PROD_W-1:0]  behind_limit;
    logic [PROD_W-1:0]  ahead_limit;
    logic               is_behind;
    logic               is_ahead;
    logic [SCORE_W:0]   behind_sum;
    logic [BLOCK_W-1:0] len_base;
    logic [BLOCK_W:0]   len_dbl;
    arlg_state_t        s;

    assign work_x100 = PROD_W'(item.work_us) * PROD_W'(PCT_SCALE);
    assign is_ahead  = work_x100 < PROD_W'(cfg.top_period_us) * PROD_W'(AHEAD_PCT);

    always_comb
    begin
        s            = st;
        behind_limit = '0;
        is_behind    = 1'b0;
        behind_sum   = '0;
        len_base     = '0;
        len_dbl      = '0;
        res.rate          = item.requested_rate;
        res.rung_index    = 1'b0;
        res.ladder_active = 1'b0;
        res.change        = CHG_NONE;

        if (!cfg.adaptive_enable)
        begin
            s.ladder_loaded = 1'b0;
        end
        else if (item.guest_rate == cfg.top_rate)
        begin
            res.rate = cfg.top_rate;
        end
        else if (item.requested_rate != cfg.top_rate || item.requested_rate == '0)
        begin
            s.ladder_loaded = 1'b0;
        end
        else
        begin
            // first adaptive word loads a fresh ladder
            if (!s.ladder_loaded)
            begin
                s.ladder_loaded   = 1'b1;
                s.rung            = 1'b0;
                s.behind_score    = '0;
                s.ahead_score     = '0;
                s.up_block_count  = '0;
                s.up_block_length = BLOCK_W'(BLOCK_BASE);
            end

            if (item.action)
            begin
                if (s.frames_since_climb < HOLD_W'(HOLD_FRAMES))
                begin
                    s.frames_since_climb = s.frames_since_climb + 1'b1;
                end

                behind_limit = (s.rung ? PROD_W'(cfg.floor_period_us)
                                       : PROD_W'(cfg.top_period_us)) * PROD_W'(BEHIND_PCT);
                is_behind = work_x100 > behind_limit;

                if (is_behind)
                begin
                    behind_sum = (SCORE_W+1)'(s.behind_score) + (SCORE_W+1)'(BEHIND_STEP);
                    if (behind_sum > (SCORE_W+1)'(SCORE_MAX))
                    begin
                        s.behind_score = SCORE_W'(SCORE_MAX);
                    end
                    else
                    begin
                        s.behind_score = behind_sum[SCORE_W-1:0];
                    end
                end
                else if (s.behind_score != '0)
                begin
                    s.behind_score = s.behind_score - 1'b1;
                end

                if (s.up_block_count != '0)
                begin
                    s.up_block_count = s.up_block_count - 1'b1;
                    s.ahead_score    = '0;
                end
                else if (s.rung)
                begin
                    if (is_ahead)
                    begin
                        if (s.ahead_score < SCORE_W'(SCORE_MAX))
                        begin
                            s.ahead_score = s.ahead_score + 1'b1;
                        end
                        else
                        begin
                            s.ahead_score = SCORE_W'(SCORE_MAX);
                        end
                    end
                    else if (s.ahead_score != '0)
                    begin
                        s.ahead_score = s.ahead_score - 1'b1;
                    end
                end

                if (s.behind_score >= SCORE_W'(cfg.behind_trip) && !s.rung)
                begin
                    s.rung         = 1'b1;
                    s.behind_score = '0;
                    s.ahead_score  = '0;
                    len_base = (s.frames_since_climb >= HOLD_W'(HOLD_FRAMES))
                             ? BLOCK_W'(BLOCK_BASE) : s.up_block_length;
                    s.up_block_count = len_base;
                    len_dbl = {len_base, 1'b0};
                    if (len_dbl > (BLOCK_W+1)'(BLOCK_MAX))
                    begin
                        s.up_block_length = BLOCK_W'(BLOCK_MAX);
                    end
                    else
                    begin
                        s.up_block_length = len_dbl[BLOCK_W-1:0];
                    end
                    res.change = CHG_DOWN;
                end
                else if (s.ahead_score >= SCORE_W'(cfg.ahead_trip) && s.rung)
                begin
                    s.rung               = 1'b0;
                    s.behind_score       = '0;
                    s.ahead_score        = '0;
                    s.frames_since_climb = '0;
                    res.change           = CHG_UP;
                end
            end

            res.rate          = s.rung ? cfg.floor_rate : cfg.top_rate;
            res.rung_index    = s.rung;
            res.ladder_active = 1'b1;
        end
    end

    assign st_next = s;

endmodule

/* sim/adaptive_rate_ladder_governor_checker.sv */
// scoreboard for the rate ladder governor: mirrors the config, predicts every result word and checks it
`timescale 1ns / 1ps

module adaptive_rate_ladder_governor_checker
    import arlg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  action,
    input  logic [RATE_W-1:0]     requested_rate,
    input  logic [RATE_W-1:0]     guest_rate,
    input  logic [WORK_BITS-1:0]  work_us,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [RATE_W-1:0]     rate,
    input  logic                  rung_index,
    input  logic                  ladder_active,
    input  logic [1:0]            change,
    output int                    fail_count,
    output int                    waiting,
    output int                    checked_count,
    output int                    down_count,
    output int                    up_count
);

    arlg_cfg_t    regs;
    arlg_state_t  ladder;
    arlg_result_t expected_rates [$];

    function automatic arlg_result_t govern_word(input arlg_item_t word);
        arlg_result_t        res;
        logic [PERIOD_W-1:0] period;
        longint unsigned     work_x;
        longint unsigned     behind_lim;
        longint unsigned     ahead_lim;
        int unsigned         behind;
        int unsigned         doubled;
        res = '0;
        res.change = CHG_NONE;
        if (!regs.adaptive_enable) begin
            ladder.ladder_loaded = 1'b0;
            res.rate = word.requested_rate;
            return res;
        end
        if (word.guest_rate == regs.top_rate) begin
            res.rate = regs.top_rate;
            return res;
        end
        if (word.requested_rate != regs.top_rate || word.requested_rate == '0) begin
            ladder.ladder_loaded = 1'b0;
            res.rate = word.requested_rate;
            return res;
        end
        if (!ladder.ladder_loaded) begin
            ladder.ladder_loaded   = 1'b1;
            ladder.rung            = 1'b0;
            ladder.behind_score    = '0;
            ladder.ahead_score     = '0;
            ladder.up_block_count  = '0;
            ladder.up_block_length = BLOCK_W'(BLOCK_BASE);
        end
        if (word.action) begin
            if (ladder.frames_since_climb < HOLD_FRAMES)
                ladder.frames_since_climb = ladder.frames_since_climb + 1'b1;
            period     = ladder.rung ? regs.floor_period_us : regs.top_period_us;
            work_x     = word.work_us;
            work_x     = work_x * PCT_SCALE;
            behind_lim = period;
            behind_lim = behind_lim * BEHIND_PCT;
            ahead_lim  = regs.top_period_us;
            ahead_lim  = ahead_lim * AHEAD_PCT;

            if (work_x > behind_lim) begin
                behind = ladder.behind_score + BEHIND_STEP;
                ladder.behind_score = SCORE_W'((behind > SCORE_MAX) ? SCORE_MAX : behind);
            end
            else if (ladder.behind_score != '0) begin
                ladder.behind_score = ladder.behind_score - 1'b1;
            end

            if (ladder.up_block_count != '0) begin
                ladder.up_block_count = ladder.up_block_count - 1'b1;
                ladder.ahead_score    = '0;
            end
            else if (ladder.rung) begin
                if (work_x < ahead_lim) begin
                    if (ladder.ahead_score < SCORE_MAX)
                        ladder.ahead_score = ladder.ahead_score + 1'b1;
                end
                else if (ladder.ahead_score != '0) begin
                    ladder.ahead_score = ladder.ahead_score - 1'b1;
                end
            end

            if (ladder.behind_score >= regs.behind_trip && !ladder.rung) begin
                ladder.rung         = 1'b1;
                ladder.behind_score = '0;
                ladder.ahead_score  = '0;
                if (ladder.frames_since_climb >= HOLD_FRAMES)
                    ladder.up_block_length = BLOCK_W'(BLOCK_BASE);
                ladder.up_block_count  = ladder.up_block_length;
                doubled                = 2 * ladder.up_block_length;
                ladder.up_block_length = BLOCK_W'((doubled > BLOCK_MAX) ? BLOCK_MAX : doubled);
                res.change = CHG_DOWN;
                down_count++;
            end
            else if (ladder.ahead_score >= regs.ahead_trip && ladder.rung) begin
                ladder.rung               = 1'b0;
                ladder.behind_score       = '0;
                ladder.ahead_score        = '0;
                ladder.frames_since_climb = '0;
                res.change = CHG_UP;
                up_count++;
            end
        end
        res.rate          = ladder.rung ? regs.floor_rate : regs.top_rate;
        res.rung_index    = ladder.rung;
        res.ladder_active = 1'b1;
        return res;
    endfunction

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        arlg_result_t want;
        arlg_item_t   word;
        if (!rst_n) begin
            regs.adaptive_enable      = 1'b0;
            regs.top_rate             = RST_TOP_RATE;
            regs.floor_rate           = RST_FLOOR_RATE;
            regs.top_period_us        = RST_TOP_PERIOD;
            regs.floor_period_us      = RST_FLOOR_PERIOD;
            regs.behind_trip          = RST_BEHIND_TRIP;
            regs.ahead_trip           = RST_AHEAD_TRIP;
            ladder                    = '0;
            ladder.up_block_length    = BLOCK_W'(BLOCK_BASE);
            ladder.frames_since_climb = HOLD_W'(HOLD_FRAMES);
            expected_rates.delete();
        end
        else begin
            if (cfg_write) begin
                case (cfg_index_t'(cfg_index))
                    REG_ADAPTIVE_ENABLE: regs.adaptive_enable = cfg_data[0];
                    REG_TOP_RATE:        regs.top_rate        = cfg_data[RATE_W-1:0];
                    REG_FLOOR_RATE:      regs.floor_rate      = cfg_data[RATE_W-1:0];
                    REG_TOP_PERIOD:      regs.top_period_us   = cfg_data[PERIOD_W-1:0];
                    REG_FLOOR_PERIOD:    regs.floor_period_us = cfg_data[PERIOD_W-1:0];
                    REG_BEHIND_TRIP:     regs.behind_trip     = cfg_data[TRIP_W-1:0];
                    REG_AHEAD_TRIP:      regs.ahead_trip      = cfg_data[TRIP_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (expected_rates.size() == 0) begin
                    $display("%0t: result word with nothing expected, expected none, actual rate %0d",
                             $time, rate);
                    fail_count++;
                end
                else begin
                    want = expected_rates.pop_front();
                    check_field("rate", want.rate, rate);
                    check_field("rung_index", want.rung_index, rung_index);
                    check_field("ladder_active", want.ladder_active, ladder_active);
                    check_field("change", want.change, change);
                    checked_count++;
                end
            end
            if (in_valid && in_ready) begin
                word.action         = action;
                word.requested_rate = requested_rate;
                word.guest_rate     = guest_rate;
                word.work_us        = work_us;
                expected_rates.push_back(govern_word(word));
            end
        end
        waiting = expected_rates.size();
    end

endmodule

/* sim/adaptive_rate_ladder_governor_tb.sv */
// testbench top for the rate ladder governor: clock, reset, config phases, stimulus and verdict
`timescale 1ns / 1ps

module adaptive_rate_ladder_governor_tb;
    import arlg_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 64;

    typedef enum {LOAD_SLOW, LOAD_FAST, LOAD_MIXED} load_mood_t;
    typedef enum {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  action         = 1'b0;
    logic [RATE_W-1:0]     requested_rate = '0;
    logic [RATE_W-1:0]     guest_rate     = '0;
    logic [WORK_BITS-1:0]  work_us        = '0;
    logic                  out_ready      = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [RATE_W-1:0]     rate;
    logic                  rung_index;
    logic                  ladder_active;
    logic [1:0]            change;

    rx_mode_t    rx_mode          = RX_MOSTLY;
    logic        squeeze_req      = 1'b0;
    logic        squeeze_ack      = 1'b0;
    int          hold_left        = 0;
    int          rx_phase         = 0;
    int          holds_done       = 0;
    int          cycle_count      = 0;
    int unsigned top_rate_now     = 60;
    int unsigned top_period_now   = 16666;
    int unsigned floor_period_now = 33333;

    int fail_count;
    int waiting;
    int checked_count;
    int down_count;
    int up_count;

    adaptive_rate_ladder_governor uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .requested_rate (requested_rate),
        .guest_rate     (guest_rate),
        .work_us        (work_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rate           (rate),
        .rung_index     (rung_index),
        .ladder_active  (ladder_active),
        .change         (change)
    );

    adaptive_rate_ladder_governor_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .requested_rate (requested_rate),
        .guest_rate     (guest_rate),
        .work_us        (work_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rate           (rate),
        .rung_index     (rung_index),
        .ladder_active  (ladder_active),
        .change         (change),
        .fail_count     (fail_count),
        .waiting        (waiting),
        .checked_count  (checked_count),
        .down_count     (down_count),
        .up_count       (up_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise a stall pattern per mode
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready   <= 1'b0;
            hold_left   <= 0;
            squeeze_ack <= 1'b0;
            rx_phase    <= 0;
        end
        else begin
            rx_phase <= rx_phase + 1;
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (squeeze_req != squeeze_ack) begin
                squeeze_ack <= squeeze_req;
                hold_left   <= HOLD_OFF_CYCLES;
                holds_done  <= holds_done + 1;
                out_ready   <= 1'b0;
            end
            else begin
                case (rx_mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= ((rx_phase % 11) < 6);
                endcase
            end
        end
    end

    task automatic send_word(input logic a, input logic [RATE_W-1:0] rq,
                             input logic [RATE_W-1:0] gr, input logic [WORK_BITS-1:0] w);
        in_valid       <= 1'b1;
        action         <= a;
        requested_rate <= rq;
        guest_rate     <= gr;
        work_us        <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input int unsigned en, input int unsigned tr, input int unsigned fr,
                             input int unsigned tp, input int unsigned fp,
                             input int unsigned bt, input int unsigned at);
        int unsigned vals [7];
        vals = '{en, tr, fr, tp, fp, bt, at};
        for (int i = 0; i < $size(vals); i++) begin
            cfg_write <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= vals[i][CFG_DATA_W-1:0];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
        top_rate_now     = tr & 32'hFF;
        top_period_now   = tp & 32'hFFFFF;
        floor_period_now = fp & 32'hFFFFF;
    endtask

    // work time on the slow side, the fast side or anywhere in between; at times zero or all ones
    function automatic logic [WORK_BITS-1:0] pick_work(input load_mood_t mood);
        longint unsigned slow_min;
        longint unsigned fast_lim;
        longint unsigned pick;
        slow_min = (top_period_now > floor_period_now) ? top_period_now : floor_period_now;
        slow_min = slow_min * 115 / 100 + 1;
        fast_lim = top_period_now;
        fast_lim = (fast_lim == 0) ? 0 : (fast_lim * 95 - 1) / 100;
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            default: ;
        endcase
        case (mood)
            LOAD_SLOW: pick = slow_min + $urandom_range(0, 64);
            LOAD_FAST: pick = $urandom_range(0, 32'(fast_lim));
            default:   pick = $urandom_range(0, 32'(slow_min + 64));
        endcase
        return (pick > 64'hFFFFFF) ? 24'hFFFFFF : pick[WORK_BITS-1:0];
    endfunction

    task automatic run_random(input int n, input int max_gap, input bit squeeze_on,
                              input int noise_pct);
        int                   burst_left;
        int                   no_gap_left;
        int                   mood_left;
        int                   gap;
        load_mood_t           mood;
        logic                 a;
        logic [RATE_W-1:0]    rq;
        logic [RATE_W-1:0]    gr;
        logic [WORK_BITS-1:0] w;
        burst_left  = $urandom_range(1, 8);
        no_gap_left = 0;
        mood_left   = 0;
        mood        = LOAD_MIXED;
        for (int i = 0; i < n; i++) begin
            if (mood_left == 0) begin
                case ($urandom_range(0, 3))
                    0: begin mood = LOAD_SLOW;  mood_left = $urandom_range(4, 16);  end
                    1: begin mood = LOAD_MIXED; mood_left = $urandom_range(5, 20);  end
                    default: begin mood = LOAD_FAST; mood_left = $urandom_range(20, 70); end
                endcase
            end
            mood_left--;
            if (squeeze_on && i == n / 3) begin
                squeeze_req <= ~squeeze_req;
                no_gap_left = 16;
            end
            if ($urandom_range(0, 99) >= noise_pct) begin
                a  = ($urandom_range(0, 9) != 0);
                rq = top_rate_now[RATE_W-1:0];
                gr = 8'($urandom_range(0, 255));
                if (gr == rq)
                    gr = gr + 8'd1;
                w  = pick_work(mood);
            end
            else begin
                a  = 1'($urandom_range(0, 1));
                w  = 24'($urandom);
                gr = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 3))
                    0: rq = '0;
                    1: rq = 8'($urandom_range(0, 255));
                    default:
                    begin
                        rq = top_rate_now[RATE_W-1:0];
                        gr = top_rate_now[RATE_W-1:0];
                    end
                endcase
            end
            send_word(a, rq, gr, w);
            if (no_gap_left > 0)
                no_gap_left--;
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = (max_gap > 0 && no_gap_left == 0) ? $urandom_range(0, max_gap) : 0;
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    initial begin
        int unsigned tp;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config, ladder off
        send_word(1'b0, 8'd0, 8'd1, 24'd0);
        send_word(1'b1, 8'd255, 8'd255, 24'hFFFFFF);
        drain();

        // zero behind trip, ahead trip past the score ceiling
        configure(1, 60, 30, 16666, 33333, 0, 127);
        send_word(1'b1, 8'd60, 8'd60, 24'hFFFFFF);
        send_word(1'b1, 8'd0, 8'd1, 24'd5);
        send_word(1'b0, 8'd255, 8'd30, 24'd0);
        send_word(1'b1, 8'd60, 8'd30, 24'd0);
        send_word(1'b1, 8'd60, 8'd30, 24'd0);
        send_word(1'b0, 8'd60, 8'd30, 24'hFFFFFF);
        drain();

        // top rate moved while the ladder is loaded
        configure(1, 90, 30, 16666, 33333, 0, 127);
        send_word(1'b1, 8'd90, 8'd30, 24'hFFFFFF);
        send_word(1'b1, 8'd90, 8'd90, 24'd0);
        drain();

        configure(0, 90, 30, 16666, 33333, 0, 127);
        send_word(1'b1, 8'd90, 8'd20, 24'd7);
        drain();

        // zero periods
        configure(1, 255, 255, 0, 0, 127, 0);
        send_word(1'b1, 8'd255, 8'd1, 24'd1);
        send_word(1'b1, 8'd255, 8'd1, 24'd0);
        drain();

        configure(1, 255, 1, 20'hFFFFF, 20'hFFFFF, 1, 0);
        send_word(1'b1, 8'd255, 8'd7, 24'hFFFFFF);
        drain();

        // top rate of zero
        configure(1, 0, 1, 20'hFFFFF, 20'hFFFFF, 1, 0);
        send_word(1'b1, 8'd0, 8'd5, 24'd3);
        send_word(1'b1, 8'd0, 8'd0, 24'd3);
        drain();

        rx_mode <= RX_MOSTLY;
        configure(1, 60, 30, 100, 200, 8, 6);
        run_random(80, 3, 1'b1, 2);
        drain();

        rx_mode <= RX_ALWAYS;
        tp = $urandom_range(20, 500);
        configure(1, $urandom_range(1, 255), $urandom_range(1, 255), tp, tp * 2,
                  $urandom_range(1, 16), $urandom_range(1, 12));
        run_random(70, 0, 1'b0, 10);
        drain();

        rx_mode <= RX_PATTERN;
        tp = $urandom_range(50, 300);
        configure(1, 120, 40, tp, tp + $urandom_range(0, tp), 4, 2);
        run_random(90, 6, 1'b1, 2);
        drain();

        rx_mode <= RX_SPARSE;
        configure(0, 200, 100, 100, 200, 8, 6);
        run_random(20, 2, 1'b0, 30);
        drain();

        rx_mode <= RX_MOSTLY;
        configure(1, 255, 1, 1, 20'hFFFFF, 127, 127);
        run_random(40, 4, 1'b0, 5);
        drain();

        rx_mode <= RX_ALWAYS;
        configure(1, 1, 255, 1000000, 1000000, 1, 1);
        run_random(40, 1, 1'b0, 5);
        drain();

        rx_mode <= RX_MOSTLY;
        tp = $urandom_range(20, 400);
        configure(1, $urandom_range(1, 255), $urandom_range(1, 255), tp, tp * 3,
                  $urandom_range(2, 12), $urandom_range(1, 8));
        run_random(80, 5, 1'b1, 4);
        drain();

        repeat (8) @(posedge clk);
        $display("checked %0d result words across directed and random config phases",
                 checked_count);
        $display("ladder stepped down %0d and up %0d times, receiver held off %0d times",
                 down_count, up_count, holds_done);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/arlg_pkg.sv
rtl/core/arlg_update.sv
rtl/core/adaptive_rate_ladder_governor.sv
sim/adaptive_rate_ladder_governor_checker.sv
sim/adaptive_rate_ladder_governor_tb.sv
